>>> src/ccbd_pkg.sv
// Shared types, codes and the CRC-32 table entry function for the batch deframer.
package ccbd_pkg;

   // Frame parsing phases, one-hot
   typedef enum logic [3:0] {
      PHASE_HEADER = 4'b0001,
      PHASE_LENGTH = 4'b0010,
      PHASE_DATA   = 4'b0100,
      PHASE_DROP   = 4'b1000
   } ccbd_phase_type;

   // Result kinds
   localparam logic KIND_EVENT  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Frame status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   // Reflected CRC-32
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

   // Header holds an 8-byte batch id and a 4-byte event count
   localparam logic [3:0] HEADER_LAST_INDEX = 4'd11;
   localparam logic [2:0] TRAILER_BYTES     = 3'd4;

   // Result queue depth
   localparam int QUEUE_DEPTH = 4;

   // One result word
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  event_data;
      logic [31:0] event_number;
      logic        event_done;
      logic [63:0] batch_ident;
      logic [31:0] event_total;
      logic [1:0]  frame_status;
      logic        run_last;
   } ccbd_result_type;

   // Words produced by one accepted input byte, in delivery order
   typedef struct packed {
      logic [1:0]      count;
      ccbd_result_type first;
      ccbd_result_type second;
   } ccbd_push_type;

   // Table entry of the reflected CRC-32 for one byte index
   function automatic logic [31:0] crc_table(input logic [7:0] index);
      logic [31:0] c;
      c = {24'd0, index};
      for (int j = 0; j < 8; j++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> src/crc_checked_batch_deframer_unit.sv
// Top level of the CRC-checked length-prefixed batch deframer.
// Data path: a content byte leaves the four-byte trailer line four bytes later; its word is
// registered into the result queue when the byte that pushes it out is accepted, as is the status.
// Throughput: one byte per cycle; a frame's final byte may add a second word, drained
// through a four-word result queue that stalls the input when fewer than two slots are free.
// Reset: synchronous, clears the parser to its header phase and empties the queue.
module crc_checked_batch_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_event_data,
   output logic [31:0] rsp_event_number,
   output logic        rsp_event_done,
   output logic [63:0] rsp_batch_ident,
   output logic [31:0] rsp_event_total,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_run_last
);
   import ccbd_pkg::*;

   logic            in_accept;
   logic            queue_full;
   ccbd_push_type   push;
   ccbd_result_type head;

   assign req_stall = queue_full;
   assign in_accept = req_valid && !queue_full;

   ccbd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .frame_byte (req_frame_byte),
      .frame_end  (req_frame_end),
      .push       (push)
   );

   ccbd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (head)
   );

   // Spread the head word onto the result ports
   assign rsp_result_kind  = head.result_kind;
   assign rsp_event_data   = head.event_data;
   assign rsp_event_number = head.event_number;
   assign rsp_event_done   = head.event_done;
   assign rsp_batch_ident  = head.batch_ident;
   assign rsp_event_total  = head.event_total;
   assign rsp_frame_status = head.frame_status;
   assign rsp_run_last     = head.run_last;

endmodule

>>> src/ccbd_parser.sv
// Trailer holding line, CRC update and frame field parser for the batch deframer.
module ccbd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  logic [7:0]             frame_byte,
   input  logic                   frame_end,
   output ccbd_pkg::ccbd_push_type push
);
   import ccbd_pkg::*;

   logic [7:0]     hold_ff [4];
   logic [7:0]     hold_in [4];
   logic [2:0]     fill_ff, fill_in;
   logic [31:0]    crc_ff, crc_in;
   ccbd_phase_type phase_ff, phase_in;
   logic [3:0]     index_ff, index_in;
   logic [63:0]    ident_ff, ident_in;
   logic [31:0]    total_ff, total_in;
   logic [31:0]    events_ff, events_in;
   logic [31:0]    bytes_ff, bytes_in;
   logic [31:0]    current_ff, current_in;

   logic [7:0]      old_byte;
   logic [31:0]     bytes_dec;
   logic [31:0]     events_dec;
   logic [31:0]     trailer_crc;
   logic            data_hit;
   ccbd_result_type data_word;
   ccbd_result_type status_word;

   // Work out the next state and the words for one byte
   always_comb begin
      hold_in    = hold_ff;
      fill_in    = fill_ff;
      crc_in     = crc_ff;
      phase_in   = phase_ff;
      index_in   = index_ff;
      ident_in   = ident_ff;
      total_in   = total_ff;
      events_in  = events_ff;
      bytes_in   = bytes_ff;
      current_in = current_ff;
      data_hit   = 1'b0;
      data_word  = '0;
      status_word = '0;
      old_byte   = hold_ff[0];
      bytes_dec  = bytes_ff - 32'd1;
      events_dec = events_ff - 32'd1;

      if (fill_ff < TRAILER_BYTES) begin
         // fill the holding line
         hold_in[fill_ff[1:0]] = frame_byte;
         fill_in = fill_ff + 3'd1;
      end else begin
         // shift the holding line; the byte leaving it is content
         hold_in[0] = hold_ff[1];
         hold_in[1] = hold_ff[2];
         hold_in[2] = hold_ff[3];
         hold_in[3] = frame_byte;
         crc_in = crc_table(crc_ff[7:0] ^ old_byte) ^ (crc_ff >> 8);

         case (phase_ff)
            PHASE_HEADER: begin
               if (!index_ff[3]) begin
                  ident_in[{index_ff[2:0], 3'b000} +: 8] = old_byte;
               end else begin
                  total_in[{index_ff[1:0], 3'b000} +: 8] = old_byte;
               end
               if (index_ff == HEADER_LAST_INDEX) begin
                  index_in  = '0;
                  events_in = total_in;
                  phase_in  = (total_in == 32'd0) ? PHASE_DROP : PHASE_LENGTH;
               end else begin
                  index_in = index_ff + 4'd1;
               end
            end
            PHASE_LENGTH: begin
               bytes_in[{index_ff[1:0], 3'b000} +: 8] = old_byte;
               if (index_ff[1:0] == 2'd3) begin
                  index_in = '0;
                  if (bytes_in == 32'd0) begin
                     // empty event: close it at once
                     events_in  = events_dec;
                     current_in = current_ff + 32'd1;
                     phase_in   = (events_dec == 32'd0) ? PHASE_DROP : PHASE_LENGTH;
                  end else begin
                     phase_in = PHASE_DATA;
                  end
               end else begin
                  index_in = index_ff + 4'd1;
               end
            end
            PHASE_DATA: begin
               data_hit                = 1'b1;
               data_word.result_kind   = KIND_EVENT;
               data_word.event_data    = old_byte;
               data_word.event_number  = current_ff;
               bytes_in                = bytes_dec;
               if (bytes_dec == 32'd0) begin
                  data_word.event_done = 1'b1;
                  events_in  = events_dec;
                  current_in = current_ff + 32'd1;
                  index_in   = '0;
                  phase_in   = (events_dec == 32'd0) ? PHASE_DROP : PHASE_LENGTH;
               end
            end
            default: begin
               // drop bytes after the last event
            end
         endcase
      end

      // Build the end-of-frame status from the updated state
      trailer_crc = {hold_in[3], hold_in[2], hold_in[1], hold_in[0]};
      status_word.result_kind = KIND_STATUS;
      status_word.batch_ident = ident_in;
      status_word.event_total = total_in;
      status_word.run_last    = 1'b1;
      if (fill_in < TRAILER_BYTES || phase_in == PHASE_HEADER) begin
         status_word.frame_status = STATUS_SHORT;
      end else if (trailer_crc != ~crc_in) begin
         status_word.frame_status = STATUS_CRC_ERROR;
      end else if (phase_in != PHASE_DROP) begin
         status_word.frame_status = STATUS_TRUNCATED;
      end else begin
         status_word.frame_status = STATUS_OK;
      end

      // Order the words for the queue
      data_word.run_last = !frame_end;
      push = '0;
      if (data_hit && frame_end) begin
         push.count  = 2'd2;
         push.first  = data_word;
         push.second = status_word;
      end else if (data_hit) begin
         push.count = 2'd1;
         push.first = data_word;
      end else if (frame_end) begin
         push.count = 2'd1;
         push.first = status_word;
      end
      if (!in_accept) begin
         push.count = 2'd0;
      end

      // Return to the start state after the final byte
      if (frame_end) begin
         for (int i = 0; i < 4; i++) begin
            hold_in[i] = '0;
         end
         fill_in    = '0;
         crc_in     = CRC_ALL_ONES;
         phase_in   = PHASE_HEADER;
         index_in   = '0;
         ident_in   = '0;
         total_in   = '0;
         events_in  = '0;
         bytes_in   = '0;
         current_in = '0;
      end
   end

   // Hold state between accepted bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            hold_ff[i] <= '0;
         end
         fill_ff    <= '0;
         crc_ff     <= CRC_ALL_ONES;
         phase_ff   <= PHASE_HEADER;
         index_ff   <= '0;
         ident_ff   <= '0;
         total_ff   <= '0;
         events_ff  <= '0;
         bytes_ff   <= '0;
         current_ff <= '0;
      end else if (in_accept) begin
         hold_ff    <= hold_in;
         fill_ff    <= fill_in;
         crc_ff     <= crc_in;
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         ident_ff   <= ident_in;
         total_ff   <= total_in;
         events_ff  <= events_in;
         bytes_ff   <= bytes_in;
         current_ff <= current_in;
      end
   end

endmodule

>>> src/ccbd_out_queue.sv
// Result word queue taking up to two words per cycle and giving one while the output is not stalled.
module ccbd_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  ccbd_pkg::ccbd_push_type   push,
   output logic                      full,
   output logic                      out_valid,
   input  logic                      out_stall,
   output ccbd_pkg::ccbd_result_type out_word
);
   import ccbd_pkg::*;

   localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   ccbd_result_type         entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]     wr_ff, wr_in;
   logic [PtrWidth-1:0]     rd_ff, rd_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    pop;
   logic [PtrWidth-1:0]     wr_next;

   // Keep room for two words before taking another byte
   assign full      = count_ff > CountWidth'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_word  = entry_ff[rd_ff];
   assign pop       = out_valid && !out_stall;
   assign wr_next   = wr_ff + PtrWidth'(1);

   // Advance pointers and count
   always_comb begin
      wr_in    = wr_ff + PtrWidth'(push.count);
      rd_in    = pop ? rd_ff + PtrWidth'(1) : rd_ff;
      count_in = count_ff + CountWidth'(push.count) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule
